>>> hw/rtl/vwps_pkg.sv
// Shared types, constants and palette table for the word-to-pixel scanout block.
`default_nettype none
package vwps_pkg;

    localparam int WORDS_PER_LINE = 32;
    localparam int CFG_AW         = 4;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [7:0] SCROLL_WRAP   = 8'o330;
    localparam logic [7:0] SCROLL_OFFSET = 8'o50;

    localparam logic [23:0] COLOUR_WHITE = 24'hFFFFFF;
    localparam logic [23:0] COLOUR_BLACK = 24'h000000;

    typedef struct packed {
        logic        opcode;
        logic [12:0] word_address;
        logic [15:0] write_data;
        logic [7:0]  line;
        logic [4:0]  column;
    } t_in_item;

    typedef struct packed {
        logic [23:0] pixel_color;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic        last_pixel;
    } t_out_item;

    typedef struct packed {
        logic       mono;
        logic       ext;
        logic [3:0] pal_sel;
    } t_pix_cfg;

    // bank 0 doubles as the fixed palette
    localparam logic [23:0] BANK_PAL [16][4] = '{
        '{24'h000000, 24'h0000FF, 24'h00FF00, 24'hFF0000},
        '{24'h000000, 24'hFFFF00, 24'hFF00FF, 24'hFF0000},
        '{24'h000000, 24'h00FFFF, 24'h0000FF, 24'hFF00FF},
        '{24'h000000, 24'h00FF00, 24'h00FFFF, 24'hFFFF00},
        '{24'h000000, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF},
        '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
        '{24'h000000, 24'h7F0000, 24'h7F0000, 24'hFF0000},
        '{24'h000000, 24'h00FF7F, 24'h00FF7F, 24'hFFFF00},
        '{24'h000000, 24'hFF00FF, 24'h7F00FF, 24'h7F007F},
        '{24'h000000, 24'h00FF7F, 24'h7F00FF, 24'h7F0000},
        '{24'h000000, 24'h00FF7F, 24'h7F007F, 24'h7F0000},
        '{24'h000000, 24'h00FFFF, 24'hFFFF00, 24'hFF0000},
        '{24'h000000, 24'hFF0000, 24'h00FF00, 24'h00FFFF},
        '{24'h000000, 24'h00FFFF, 24'hFFFF00, 24'hFFFFFF},
        '{24'h000000, 24'hFFFF00, 24'h00FF00, 24'hFFFFFF},
        '{24'h000000, 24'h00FFFF, 24'h00FF00, 24'hFFFFFF}
    };

    function automatic logic [23:0] f_palette(logic ext, logic [3:0] sel, logic [1:0] idx);
        logic [3:0] bank;
        bank = ext ? sel : 4'd0;
        return BANK_PAL[bank][idx];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/video_word_to_pixel_scanout.sv
// Top level: register port, sequencer with index reduction, video memory and pixel serialiser.
// Render: take the command, reduce the address, read the memory, load the serialiser, look up
//   the colour, then 16 pixel transfers on consecutive cycles, after which busy drops.
// Write: take the command, reduce the address, write the memory. A new command is taken only while busy is low.
// After reset the memory is swept to zero, one word per cycle over all VIDEO_WORDS words, busy high.
// Results cannot be held off by the receiver.
`default_nettype none
module video_word_to_pixel_scanout #(
    parameter int VIDEO_WORDS        = 8192,
    parameter int SMALL_SCREEN_LINES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire vwps_pkg::t_in_item            i_item,
    output logic                               o_strobe,
    output vwps_pkg::t_out_item                o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vwps_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int AW = $clog2(VIDEO_WORDS);
    localparam logic [13:0] VW_WIDE = 14'(VIDEO_WORDS);
    localparam logic [12:0] VW_SUB  = 13'(VIDEO_WORDS);
    localparam logic [AW-1:0] CLR_LAST = AW'(VIDEO_WORDS - 1);
    localparam logic [8:0] SMALL_LINES = 9'(SMALL_SCREEN_LINES);

    localparam logic [1:0] REG_SCROLL = 2'd0;
    localparam logic [1:0] REG_EXT    = 2'd1;
    localparam logic [1:0] REG_PAL    = 2'd2;
    localparam logic [1:0] REG_MONO   = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_REDUCE, S_WRITE, S_READ, S_LOAD, S_EMIT
    } t_state;

    t_state      r_state;
    logic [AW-1:0] r_clr;
    logic        r_op;
    logic [12:0] r_addr;
    logic [15:0] r_data;
    logic [7:0]  r_line;
    logic [4:0]  r_column;
    logic        r_blank;

    logic [9:0]  r_scroll;
    logic        r_ext;
    logic [3:0]  r_pal_sel;
    logic        r_mono;

    logic [7:0]  scroll_adj;
    logic [7:0]  row;
    logic [12:0] rd_idx;
    logic        blank;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [15:0]   ram_rdata;

    logic               pix_active;
    vwps_pkg::t_pix_cfg pix_cfg;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll  <= 10'd0;
            r_ext     <= 1'b0;
            r_pal_sel <= 4'd0;
            r_mono    <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SCROLL: r_scroll  <= pwdata[9:0];
                REG_EXT:    r_ext     <= pwdata[0];
                REG_PAL:    r_pal_sel <= pwdata[3:0];
                REG_MONO:   r_mono    <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCROLL: prdata = {22'd0, r_scroll};
            REG_EXT:    prdata = {31'd0, r_ext};
            REG_PAL:    prdata = {28'd0, r_pal_sel};
            REG_MONO:   prdata = {31'd0, r_mono};
            default:    prdata = 32'd0;
        endcase
    end

    // read index and small-screen blanking
    always_comb begin
        if (r_scroll[7:0] >= vwps_pkg::SCROLL_WRAP) begin
            scroll_adj = r_scroll[7:0] - vwps_pkg::SCROLL_WRAP;
        end else begin
            scroll_adj = r_scroll[7:0] + vwps_pkg::SCROLL_OFFSET;
        end
        row    = i_item.line + scroll_adj;
        rd_idx = {row, i_item.column};
        blank  = !r_scroll[9] && ({1'b0, i_item.line} >= SMALL_LINES);
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_item.opcode;
                        r_addr   <= (i_item.opcode == vwps_pkg::OP_RENDER) ?
                                    rd_idx : i_item.word_address;
                        r_data   <= i_item.write_data;
                        r_line   <= i_item.line;
                        r_column <= i_item.column;
                        r_blank  <= blank;
                        r_state  <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    // wrap the index into the memory by repeated subtraction
                    if ({1'b0, r_addr} >= VW_WIDE) begin
                        r_addr <= r_addr - VW_SUB;
                    end else if (r_op == vwps_pkg::OP_RENDER) begin
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: r_state <= S_IDLE;
                S_READ:  r_state <= S_LOAD;
                S_LOAD:  r_state <= S_EMIT;
                S_EMIT: begin
                    if (!pix_active) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
        ram_waddr = (r_state == S_CLEAR) ? r_clr : r_addr[AW-1:0];
        ram_wdata = (r_state == S_CLEAR) ? 16'd0 : r_data;
        ram_re    = (r_state == S_READ);
    end

    vwps_vram #(
        .DEPTH (VIDEO_WORDS),
        .AW    (AW)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        pix_cfg.mono    = r_mono;
        pix_cfg.ext     = r_ext;
        pix_cfg.pal_sel = r_pal_sel;
    end

    vwps_pixel u_pixel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_state == S_LOAD),
        .i_word   (r_blank ? 16'd0 : ram_rdata),
        .i_line   (r_line),
        .i_column (r_column),
        .i_cfg    (pix_cfg),
        .o_active (pix_active),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_strobe_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_state == S_EMIT))
        else $error("pixel transfer outside emit phase");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_pixel) |=> !o_strobe)
        else $error("pixel transfer after last pixel");

    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_pixel) |=> o_strobe)
        else $error("gap inside pixel burst");

    a_busy_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (busy && !o_strobe))
        else $error("not busy during memory clear");

endmodule
`default_nettype wire

>>> hw/rtl/vwps_vram.sv
// Video word memory: one write port, one read port with registered data.
`default_nettype none
module vwps_vram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [15:0]        o_rdata
);

    logic [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/vwps_pixel.sv
// Pixel serialiser: steps through one word, one pixel per cycle, with colour lookup.
`default_nettype none
module vwps_pixel (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic [15:0]         i_word,
    input  wire logic [7:0]          i_line,
    input  wire logic [4:0]          i_column,
    input  wire vwps_pkg::t_pix_cfg  i_cfg,
    output logic                     o_active,
    output logic                     o_strobe,
    output vwps_pkg::t_out_item      o_result
);

    logic        r_active;
    logic        r_strobe;
    logic [3:0]  r_k;
    logic [15:0] r_word;
    logic [7:0]  r_line;
    logic [4:0]  r_column;
    vwps_pkg::t_out_item r_result;

    logic [1:0]  pair;
    logic [23:0] colour;

    always_comb begin
        pair = {r_word[{r_k[3:1], 1'b1}], r_word[{r_k[3:1], 1'b0}]};
        if (i_cfg.mono) begin
            colour = r_word[r_k] ? vwps_pkg::COLOUR_WHITE : vwps_pkg::COLOUR_BLACK;
        end else begin
            colour = vwps_pkg::f_palette(i_cfg.ext, i_cfg.pal_sel, pair);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
            r_k      <= 4'd0;
        end else begin
            r_strobe <= r_active;
            if (i_load) begin
                r_active <= 1'b1;
                r_k      <= 4'd0;
            end else if (r_active) begin
                r_k <= r_k + 4'd1;
                if (r_k == 4'd15) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word   <= i_word;
            r_line   <= i_line;
            r_column <= i_column;
        end
        if (r_active) begin
            r_result.pixel_color <= colour;
            r_result.pixel_x     <= {r_column, r_k};
            r_result.pixel_y     <= r_line;
            r_result.last_pixel  <= (r_k == 4'd15);
        end
    end

    assign o_active = r_active;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire
